// ----- hdl/cpe_pkg.sv -----
// Shared types, register indexes and channel expansion table for the CLUT pixel expander.
package cpe_pkg;

	localparam int COLOR_W     = 16;
	localparam int CHAN_W      = 8;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 2;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [CHAN_W-1:0]  chan_t;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_MODE  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_ROW = 1'b1;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// pixel depth modes
	localparam logic MODE_4BPP = 1'b0;
	localparam logic MODE_8BPP = 1'b1;

	localparam chan_t ALPHA_CLEAR  = 8'd0;
	localparam chan_t ALPHA_HALF   = 8'd127;
	localparam chan_t ALPHA_OPAQUE = 8'd255;

	// floor(c * 255 / 31) for every 5-bit channel value
	localparam chan_t EXPAND5 [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

endpackage

// ----- hdl/cpe_palette.sv -----
// Palette color memory: one write port, one read port with registered read data.
module cpe_palette #(
	parameter  int DEPTH  = 1024,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  cpe_pkg::color_t     wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output cpe_pkg::color_t     rd_data
);
	import cpe_pkg::*;

	color_t mem [DEPTH];
	color_t rd_data_q;

	// a read and a write to the same entry in one cycle return the old word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/clut_pixel_expander.sv -----
// Top level of the CLUT pixel expander: palette writes and pixel byte to RGBA8888 conversion.
//
// The block holds PALETTE_ROWS rows of ROW_ENTRIES 16-bit color words in a single-port-read
// memory. A write transaction (operation = 0) stores one entry and yields no result; a pixel
// transaction (operation = 1) looks up the selected palette row and yields RGBA results with
// each 5-bit channel expanded to 8 bits and alpha set to 0, 127 or 255 by the transparency rule.
// Write transactions and 8 bpp pixel bytes are taken one per cycle while out_stall lets the
// pipe advance; a 4 bpp pixel byte holds the input until its second read issues, since its two
// palette reads share the memory's one read port and one result leaves per cycle. A pixel
// byte passes the issue register, then the memory read register, then the result register. Palette contents are
// undefined until written; no clearing pass runs after reset. Change configuration only while
// the block is idle.
module clut_pixel_expander #(
	parameter int PALETTE_ROWS = 4,
	parameter int ROW_ENTRIES  = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_write,
	input  logic [cpe_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cpe_pkg::CFG_DATA_W-1:0]      cfg_data,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [1:0]                          entry_row,
	input  logic [7:0]                          entry_index,
	input  logic [15:0]                         entry_color,
	input  logic [7:0]                          pixel_byte,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	output logic [7:0]                          alpha,
	output logic                                last_pixel
);
	import cpe_pkg::*;

	localparam int DEPTH  = PALETTE_ROWS * ROW_ENTRIES;
	localparam int ADDR_W = $clog2(DEPTH);

	// configuration registers
	logic       depth_mode_q;
	logic [1:0] palette_row_q;

	// stage 1: pixel byte waiting to issue its palette reads
	logic       valid_s1;
	logic       phase_s1;       // 0 = low nibble next, 1 = high nibble next
	logic [7:0] byte_s1;

	// stage 2: palette read in flight
	logic       valid_s2;
	logic       last_s2;
	logic       oob_s2;         // index beyond the row: force color word zero
	color_t     rd_color;

	// result register
	logic       out_valid_q;
	chan_t      red_q;
	chan_t      green_q;
	chan_t      blue_q;
	chan_t      alpha_q;
	logic       last_q;

	logic              in_accept;
	logic              out_free;
	logic              s2_free;
	logic              issue;
	logic              issue_last;
	logic              row_ok;
	logic              wr_ok;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        rd_index;
	logic              rd_oob;
	logic [ADDR_W-1:0] rd_addr;
	color_t            color_s2;
	chan_t             red_d;
	chan_t             green_d;
	chan_t             blue_d;
	chan_t             alpha_d;

	// ------------------------------------------------------------------
	// Configuration: plain register writes, no read-back
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q  <= MODE_8BPP;
			palette_row_q <= 2'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEPTH_MODE:  depth_mode_q  <= cfg_data[0];
				REG_PALETTE_ROW: palette_row_q <= cfg_data[1:0];
				default:         ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control: each stage advances when the one after it frees up
	// ------------------------------------------------------------------
	assign out_free   = !out_valid_q || !out_stall;
	assign s2_free    = !valid_s2 || out_free;
	assign issue      = valid_s1 && s2_free;
	assign issue_last = (depth_mode_q == MODE_8BPP) || phase_s1;

	// Take a new transaction once the held byte issues its final read. A write taken in
	// that cycle lands at the same edge as the read, which still sees the old word.
	assign in_stall  = valid_s1 && !(issue && issue_last);
	assign in_accept = in_valid && !in_stall;

	// selected row beyond the store: pixel bytes yield nothing
	assign row_ok = (32'(palette_row_q) < PALETTE_ROWS);

	// ------------------------------------------------------------------
	// Palette writes: drop those outside the store
	// ------------------------------------------------------------------
	assign wr_ok   = (32'(entry_row) < PALETTE_ROWS) && (32'(entry_index) < ROW_ENTRIES);
	assign wr_en   = in_accept && (operation == OP_WRITE) && wr_ok;
	assign wr_addr = ADDR_W'(32'(entry_row) * ROW_ENTRIES + 32'(entry_index));

	// ------------------------------------------------------------------
	// Stage 1: hold the pixel byte, step through its nibbles
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= (operation == OP_PIXEL) && row_ok;
			phase_s1 <= 1'b0;
		end else if (issue) begin
			if (issue_last) begin
				valid_s1 <= 1'b0;
			end else begin
				phase_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= pixel_byte;
		end
	end

	always_comb begin
		if (depth_mode_q == MODE_8BPP) begin
			rd_index = byte_s1;
		end else if (phase_s1) begin
			rd_index = {4'd0, byte_s1[7:4]};
		end else begin
			rd_index = {4'd0, byte_s1[3:0]};
		end
	end

	assign rd_oob  = (32'(rd_index) >= ROW_ENTRIES);
	assign rd_addr = ADDR_W'(32'(palette_row_q) * ROW_ENTRIES + 32'(rd_index));

	cpe_palette #(
		.DEPTH   (DEPTH)
	) u_palette (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (entry_color),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (rd_color)
	);

	// ------------------------------------------------------------------
	// Stage 2: read data arrives; its control travels alongside
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (issue) begin
			valid_s2 <= 1'b1;
		end else if (out_free) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s2 <= issue_last;
			oob_s2  <= rd_oob;
		end
	end

	// Expand channels and pick alpha: zero word is clear, transparency bit on a
	// non-black color is half, everything else (black with the bit set too) is opaque.
	assign color_s2 = oob_s2 ? '0 : rd_color;
	assign red_d    = EXPAND5[color_s2[4:0]];
	assign green_d  = EXPAND5[color_s2[9:5]];
	assign blue_d   = EXPAND5[color_s2[14:10]];

	always_comb begin
		if (color_s2 == '0) begin
			alpha_d = ALPHA_CLEAR;
		end else if (color_s2[15] && (color_s2[14:0] != '0)) begin
			alpha_d = ALPHA_HALF;
		end else begin
			alpha_d = ALPHA_OPAQUE;
		end
	end

	// ------------------------------------------------------------------
	// Result register: hold while stalled, advance otherwise
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
			alpha_q <= alpha_d;
			last_q  <= last_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = red_q;
	assign green      = green_q;
	assign blue       = blue_q;
	assign alpha      = alpha_q;
	assign last_pixel = last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// a held byte only lets a new transaction in as it issues its final read
	a_accept_frees_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_stall |-> issue && issue_last)
		else $error("new transaction taken while a pixel byte still has reads to issue");

	// a low-nibble read in flight always has its high nibble waiting behind it
	a_s2_pair: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !last_s2 |-> valid_s1 && phase_s1)
		else $error("low-nibble read in flight without its high-nibble partner");

	// a first-of-two result always has its partner behind it in the pipe
	a_out_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_pixel |-> (valid_s1 && phase_s1) || (valid_s2 && last_s2))
		else $error("first-of-two result without its partner in the pipe");

	// clear alpha comes only with black
	a_clear_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (alpha == ALPHA_CLEAR) |-> (red == '0) && (green == '0) && (blue == '0))
		else $error("clear alpha on a non-black pixel");

endmodule

// ----- sim/clut_pixel_expander_check.sv -----
`timescale 1ns / 100ps
// Checker for the CLUT pixel expander: mirrors the palette, predicts each RGBA pixel and compares.
module clut_pixel_expander_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [cpe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cpe_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            operation,
	input  logic [1:0]                      entry_row,
	input  logic [7:0]                      entry_index,
	input  logic [15:0]                     entry_color,
	input  logic [7:0]                      pixel_byte,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [7:0]                      red,
	input  logic [7:0]                      green,
	input  logic [7:0]                      blue,
	input  logic [7:0]                      alpha,
	input  logic                            last_pixel,
	output int                              failures,
	output int                              pending
);
	import cpe_pkg::*;

	localparam int ROWS    = 4;
	localparam int ENTRIES = 256;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		chan_t alpha;
		logic  last;
	} rgba_t;

	rgba_t  pending_pixels [$];
	color_t palette_copy [ROWS][ENTRIES];
	logic   depth_mode;
	logic [1:0] lookup_row;
	int     mismatches;

	function automatic chan_t widen5(input logic [4:0] c);
		return chan_t'((int'(c) * 255) / 31);
	endfunction

	function automatic rgba_t shade(input color_t col, input logic last);
		rgba_t px;
		px.red   = widen5(col[4:0]);
		px.green = widen5(col[9:5]);
		px.blue  = widen5(col[14:10]);
		// a zero word is fully clear; the transparency bit only halves a non-black color
		if (col == '0)
			px.alpha = ALPHA_CLEAR;
		else if (col[15] && (px.red | px.green | px.blue) != '0)
			px.alpha = ALPHA_HALF;
		else
			px.alpha = ALPHA_OPAQUE;
		px.last = last;
		return px;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rgba_t want;
		if (!arst_n) begin
			pending_pixels.delete();
			depth_mode = MODE_8BPP;
			lookup_row = 2'd0;
			mismatches = 0;
			failures <= 0;
			pending  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t: unexpected pixel: expected none, actual %0d/%0d/%0d/%0d last %0d",
						$time, red, green, blue, alpha, last_pixel);
					mismatches++;
				end else begin
					want = pending_pixels.pop_front();
					compare_field("red", want.red, red);
					compare_field("green", want.green, green);
					compare_field("blue", want.blue, blue);
					compare_field("alpha", want.alpha, alpha);
					compare_field("last_pixel", want.last, last_pixel);
				end
			end
			if (in_valid && !in_stall) begin
				if (operation == OP_WRITE) begin
					palette_copy[entry_row][entry_index] = entry_color;
				end else if (depth_mode == MODE_8BPP) begin
					pending_pixels.push_back(shade(palette_copy[lookup_row][pixel_byte], 1'b1));
				end else begin
					pending_pixels.push_back(shade(palette_copy[lookup_row][pixel_byte[3:0]], 1'b0));
					pending_pixels.push_back(shade(palette_copy[lookup_row][pixel_byte[7:4]], 1'b1));
				end
			end
			if (cfg_write) begin
				if (cfg_index == REG_DEPTH_MODE)
					depth_mode = cfg_data[0];
				else if (cfg_index == REG_PALETTE_ROW)
					lookup_row = cfg_data[1:0];
			end
			failures <= mismatches;
			pending  <= pending_pixels.size();
		end
	end

endmodule

// ----- sim/clut_pixel_expander_test.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the CLUT pixel expander: palette writes, pixel bytes in both depths.
module clut_pixel_expander_test;
	import cpe_pkg::*;

	localparam int CYCLE_LIMIT    = 100000;
	localparam int HOLDOFF_CYCLES = 200;
	localparam int SETTLE_CYCLES  = 8;   // comfortably longer than a pixel takes to pass the pipeline
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 30;

	// corner colors for the opening checks: clear, white, black with transparency,
	// white with transparency, pure channels and a mixed semi-transparent word
	localparam color_t     PROBE_COLORS [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
		16'h001F, 16'h03E0, 16'h7C00, 16'h8421};
	localparam logic [7:0] PROBE_INDEX  [8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd255};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_write   = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;
	logic                   in_valid    = 1'b0;
	logic                   operation   = OP_WRITE;
	logic [1:0]             entry_row   = '0;
	logic [7:0]             entry_index = '0;
	logic [15:0]            entry_color = '0;
	logic [7:0]             pixel_byte  = '0;
	logic                   out_stall   = 1'b0;

	logic       in_stall;
	logic       out_valid;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       last_pixel;

	int failures;
	int pending;

	// traffic shaping shared between the sender and the receiver
	bit calm         = 1'b0;
	bit stall_burst  = 1'b0;
	bit burst_done   = 1'b0;
	int burst_cycles = 0;
	int cycles       = 0;

	// which palette entries hold a value; pixels may only look those up
	bit row_written [4][256];
	// the configuration as last written
	logic       depth_sel = MODE_8BPP;
	logic [1:0] row_sel   = 2'd0;

	always #1 clk = ~clk;

	clut_pixel_expander #(
		.PALETTE_ROWS(4),
		.ROW_ENTRIES (256)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.entry_row  (entry_row),
		.entry_index(entry_index),
		.entry_color(entry_color),
		.pixel_byte (pixel_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.last_pixel (last_pixel)
	);

	clut_pixel_expander_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.entry_row  (entry_row),
		.entry_index(entry_index),
		.entry_color(entry_color),
		.pixel_byte (pixel_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.last_pixel (last_pixel),
		.failures   (failures),
		.pending    (pending)
	);

	// Receiver: hold off once for a long stretch so the block backs up into its input,
	// stay ready throughout a calm phase, otherwise stall at random.
	always @(posedge clk) begin
		if (stall_burst && !burst_done) begin
			out_stall    <= 1'b1;
			burst_cycles <= burst_cycles + 1;
			if (burst_cycles == HOLDOFF_CYCLES - 1)
				burst_done <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 23);
		end
	end

	// Watchdog: end the run if it hangs anywhere.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one transaction and hold it until the block takes it. Leave valid high on
	// return so that a following transaction can go out back to back.
	task automatic send_item(input logic op, input logic [1:0] row, input logic [7:0] index,
		input color_t color, input logic [7:0] byte_val);
		// idle each cycle with the same odds before offering
		if (!calm) begin
			while ($urandom_range(0, 99) < 23) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid    <= 1'b1;
		operation   <= op;
		entry_row   <= row;
		entry_index <= index;
		entry_color <= color;
		pixel_byte  <= byte_val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Store one palette entry; the pixel byte is a don't-care and goes out random.
	task automatic write_entry(input logic [1:0] row, input logic [7:0] index, input color_t color);
		row_written[row][index] = 1'b1;
		send_item(OP_WRITE, row, index, color, 8'($urandom_range(0, 255)));
	endtask

	// Convert one image byte; the entry fields are don't-cares and go out random.
	task automatic send_pixel(input logic [7:0] byte_val);
		send_item(OP_PIXEL, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535)), byte_val);
	endtask

	// Drop valid, wait for every predicted pixel, then let any trailing palette write drain.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_config(input logic mode, input logic [1:0] row);
		wait_idle();
		write_reg(REG_DEPTH_MODE, {1'b0, mode});
		write_reg(REG_PALETTE_ROW, row);
		depth_sel = mode;
		row_sel   = row;
	endtask

	// Bias colors toward the alpha corners: clear, black with transparency, semi-transparent.
	function automatic color_t pick_color();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'h8000;
			2:       return {1'b1, 15'($urandom_range(0, 32767))};
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		logic [7:0] pick;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corner colors into row 0, one write to the far row at index 0xAA,
		// then look each corner color up in 8 bpp (the reset mode) and pairs of them in 4 bpp.
		for (int i = 0; i < 8; i++)
			write_entry(2'd0, PROBE_INDEX[i], PROBE_COLORS[i]);
		write_entry(2'd3, 8'hAA, 16'h5555);
		for (int i = 0; i < 8; i++)
			send_pixel(PROBE_INDEX[i]);
		apply_config(MODE_4BPP, 2'd0);
		send_pixel(8'h10);
		send_pixel(8'h32);
		send_pixel(8'h54);
		send_pixel(8'h06);

		// Random phases: sweep every row in both depths. Each phase fills the nibble range
		// of its row first, then mixes pixels with overwrites and writes to other rows.
		for (int phase = 0; phase < PHASES; phase++) begin
			apply_config(((phase / 4) % 2 == 1) ? MODE_8BPP : MODE_4BPP, 2'(phase % 4));
			if (phase == 3)
				stall_burst <= 1'b1;
			calm <= (phase == 5);
			for (int i = 0; i < 16; i++)
				if (!row_written[row_sel][i])
					write_entry(row_sel, 8'(i), pick_color());
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// pause the sender once mid-phase until the output has drained
				if (phase == 7 && n == 20)
					wait_idle();
				if ($urandom_range(0, 99) < 15) begin
					write_entry(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), pick_color());
				end else begin
					pick = 8'($urandom_range(0, 255));
					// never look up an entry that holds nothing yet
					if (depth_sel == MODE_8BPP && !row_written[row_sel][pick])
						write_entry(row_sel, pick, pick_color());
					send_pixel(pick);
				end
			end
		end

		wait_idle();
		if (failures == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
